// ===== hw/rtl/ascending_exchange_sorter_macros.svh =====
// Assertion macros used by the checker file.
// Both macros use the clk and arst_n found in the scope where they are used.
`ifndef ASCENDING_EXCHANGE_SORTER_MACROS_SVH
`define ASCENDING_EXCHANGE_SORTER_MACROS_SVH

// Same-cycle implication
`define AES_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Next-cycle implication
`define AES_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

// ===== hw/rtl/aes_pkg.sv =====
`default_nettype none
package aes_pkg;

	localparam int DATA_W        = 32;
	localparam int MAX_ITEMS_DEF = 64;

	// Data each cell shows to its neighbors
	typedef struct packed {
		logic                     valid;
		logic                     lt;     // new element belongs at or before this cell
		logic signed [DATA_W-1:0] value;
	} link_t;

	// Chain-wide control
	typedef struct packed {
		logic insert;
		logic shift;
	} ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/aes_cell.sv =====
`default_nettype none
module aes_cell (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire aes_pkg::ctrl_t              ctrl,
	input  wire logic signed [aes_pkg::DATA_W-1:0] din,
	input  wire aes_pkg::link_t              prev,
	input  wire aes_pkg::link_t              next,
	output aes_pkg::link_t                   link
);

	logic                              valid_q;
	logic signed [aes_pkg::DATA_W-1:0] value_q;
	logic                              lt;

	// Empty cells count as larger than anything
	assign lt = !valid_q || (din < value_q);

	assign link.valid = valid_q;
	assign link.lt    = lt;
	assign link.value = value_q;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next.valid;
		end else if (ctrl.insert && lt) begin
			valid_q <= prev.lt ? prev.valid : 1'b1;
		end
	end

	// Payload: shift toward the head on emit, make room on insert
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= next.value;
		end else if (ctrl.insert && lt) begin
			value_q <= prev.lt ? prev.value : din;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/ascending_exchange_sorter.sv =====
`default_nettype none
// Ascending sorter built as an insertion chain of MAX_ITEMS cells.
//
// Requests: drive value and is_last with start high; a request is taken at a
// rising edge where start is high and busy is low. While loading, busy stays
// low, so one request is taken every cycle.
// Each request drops its value into the chain: every cell compares
// the new value with its own and either keeps, takes the value, or takes its
// left neighbor's value. Values arriving once MAX_ITEMS are held are dropped.
// The request with is_last set closes the block. From the next cycle busy is
// high and the sorted block leaves from the head cell, one result per cycle,
// smallest first, each shown on sorted_value for one cycle with strobe high;
// last_out marks the final one.
// Results cannot be held off; the receiver must take each in its cycle.
// Reset empties the chain and ends any emission in progress.
module ascending_exchange_sorter #(
	parameter int MAX_ITEMS = aes_pkg::MAX_ITEMS_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    start,
	output logic                                   busy,
	input  wire logic signed [aes_pkg::DATA_W-1:0] value,
	input  wire                                    is_last,
	output logic                                   strobe,
	output logic signed [aes_pkg::DATA_W-1:0]      sorted_value,
	output logic                                   last_out
);

	aes_pkg::link_t link [MAX_ITEMS];
	aes_pkg::ctrl_t ctrl;
	logic           emit_q;
	logic           accept;
	logic           full;

	assign accept      = start && !emit_q;
	assign full        = link[MAX_ITEMS-1].valid;
	assign ctrl.insert = accept && !full;
	assign ctrl.shift  = emit_q;

	// Emission runs until the head holds the only remaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b0;
		end else if (emit_q) begin
			emit_q <= link[1].valid;
		end else if (accept && is_last) begin
			emit_q <= 1'b1;
		end
	end

	assign busy         = emit_q;
	assign strobe       = emit_q;
	assign sorted_value = link[0].value;
	assign last_out     = !link[1].valid;

	// Cell chain
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		aes_pkg::link_t prev_l;
		aes_pkg::link_t next_l;

		if (i == 0) begin : g_head
			assign prev_l = '0;
		end else begin : g_prev
			assign prev_l = link[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_tail
			assign next_l = '0;
		end else begin : g_next
			assign next_l = link[i+1];
		end

		aes_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.din    (value),
			.prev   (prev_l),
			.next   (next_l),
			.link   (link[i])
		);
	end

endmodule
`default_nettype wire

// ===== hw/rtl/aes_checker.sv =====
`default_nettype none
`include "ascending_exchange_sorter_macros.svh"
module aes_checker (
	input wire                                    clk,
	input wire                                    arst_n,
	input wire                                    start,
	input wire                                    busy,
	input wire                                    is_last,
	input wire                                    strobe,
	input wire logic signed [aes_pkg::DATA_W-1:0] sorted_value,
	input wire                                    last_out
);

	// Closing request starts emission right away
	`AES_ASSERT_NEXT(a_close_emits, start && !busy && is_last, strobe && busy)
	// Emission is contiguous until the last result
	`AES_ASSERT_NEXT(a_emit_contig, strobe && !last_out, strobe)
	// Last result frees the block
	`AES_ASSERT_NEXT(a_last_frees, strobe && last_out, !strobe && !busy)
	// Results come out in ascending order
	`AES_ASSERT_NEXT(a_ascending, strobe && !last_out, sorted_value >= $past(sorted_value))
	// No result while loading
	`AES_ASSERT_SAME(a_strobe_busy, strobe, busy)

endmodule

bind ascending_exchange_sorter aes_checker u_aes_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.is_last      (is_last),
	.strobe       (strobe),
	.sorted_value (sorted_value),
	.last_out     (last_out)
);
`default_nettype wire
